>>> hw/rtl/vlfo_pkg.sv
`default_nettype none

package vlfo_pkg;

    localparam int PHASE_BITS = 16;
    localparam int GAIN_BITS  = 16;
    localparam int SINE_BITS  = 15;
    localparam int QTAB_DEPTH = 257;
    localparam int QTAB_AW    = 9;
    localparam int PROD_BITS  = 51;
    localparam int OUT_BITS   = 20;

    localparam logic [GAIN_BITS:0]  GAIN_ONE = 17'h10000;
    localparam logic [20:0]         OUT_MAX  = 21'd524287;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_NOTE_ON = 1'b1;

    localparam logic [1:0] CFG_PHASE_STEP   = 2'd0;
    localparam logic [1:0] CFG_DEPTH_Q8     = 2'd1;
    localparam logic [1:0] CFG_ONSET_LENGTH = 2'd2;
    localparam logic [1:0] CFG_ONSET_STEP   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL1 = 4'b0010,
        ST_MUL2 = 4'b0100,
        ST_RND  = 4'b1000
    } state_t;

    typedef logic [QTAB_DEPTH-1:0][SINE_BITS-1:0] qtab_t;

    // Quarter-wave sine in Q15 from a Q30 odd polynomial in a Q16 fraction.
    function automatic logic [SINE_BITS-1:0] quarter_sine(input longint u);
        longint u2;
        longint p;
        longint s;
        longint r;
        u2 = (u * u) / 65536;
        p  = 172272;
        p  = -5026995 + (p * u2) / 65536;
        p  = 85569306 + (p * u2) / 65536;
        p  = -693598668 + (p * u2) / 65536;
        p  = 1686629713 + (p * u2) / 65536;
        s  = (p * u) / 65536;
        if (s < 0)
        begin
            s = 0;
        end
        if (s > 64'sd1073741824)
        begin
            s = 64'sd1073741824;
        end
        r = (s * 32767 + 64'sd536870912) / 64'sd1073741824;
        return r[SINE_BITS-1:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int m = 0; m < QTAB_DEPTH; m++)
        begin
            t[m] = quarter_sine(longint'(m) * 256);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

endpackage

`default_nettype wire

>>> hw/rtl/vlfo_sine_rom.sv
`default_nettype none

module vlfo_sine_rom (
    input  wire logic                            clk,
    input  wire logic                            rd_en,
    input  wire logic [vlfo_pkg::QTAB_AW-1:0]    rd_addr,
    output logic      [vlfo_pkg::SINE_BITS-1:0]  rd_data
);

    logic [vlfo_pkg::SINE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= vlfo_pkg::QTAB[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/vibrato_lfo_with_onset_ramp_unit.sv
`default_nettype none
// A sample tick reads the sine table at its accepting edge, runs two passes through one
// shared 32x19 multiplier in states MUL1 and MUL2, then rounds into the output register in
// state RND.
// A tick is taken only while no earlier tick is in flight; a note-on gives no word.
// The input side is ready only while the sequencer is idle, and a waiting word stalls it.
// Reset (rst_n low, asynchronous) idles the sequencer, drops the output valid flag, clears
// the configuration and the onset count, sets phase to zero and gain to unity.

module vibrato_lfo_with_onset_ramp_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] start_phase
    input  wire logic        s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [19:0] cents_q8, [23:20] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    vlfo_pkg::state_t state_reg, state_next;

    logic [14:0] phase_step_reg;
    logic [18:0] depth_q8_reg;
    logic [19:0] onset_length_reg;
    logic [16:0] onset_step_reg;

    logic [15:0] phase_reg;
    logic [16:0] gain_reg, gain_next;
    logic [19:0] remaining_reg, remaining_next;

    logic                              neg_reg;
    logic [vlfo_pkg::PROD_BITS-1:0]    prod_reg;
    logic                              m_tvalid_reg;
    logic [vlfo_pkg::OUT_BITS-1:0]     cents_reg;

    logic        in_accept;
    logic        tick_accept;
    logic        note_accept;
    logic [9:0]  tab_idx;
    logic [8:0]  rom_addr;
    logic [14:0] rom_data;
    logic [19:0] remaining_dec;
    logic [17:0] gain_sum;
    logic [31:0] mul_a;
    logic [18:0] mul_b;
    logic [vlfo_pkg::PROD_BITS-1:0] mul_p;
    logic [51:0] rnd_sum;
    logic [20:0] rnd_mag;
    logic [19:0] mag_sat;
    logic        out_load;

    assign s_tready    = (state_reg == vlfo_pkg::ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign in_accept   = s_tvalid && s_tready;
    assign tick_accept = in_accept && (s_tuser == vlfo_pkg::OP_TICK);
    assign note_accept = in_accept && (s_tuser == vlfo_pkg::OP_NOTE_ON);

    assign tab_idx  = phase_reg[15:6];
    assign rom_addr = tab_idx[8] ? (9'd256 - {1'b0, tab_idx[7:0]}) : {1'b0, tab_idx[7:0]};

    vlfo_sine_rom u_rom (
        .clk     (clk),
        .rd_en   (tick_accept),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    assign remaining_dec = remaining_reg - 20'd1;
    assign gain_sum      = {1'b0, gain_reg} + {1'b0, onset_step_reg};

    always_comb
    begin
        remaining_next = remaining_reg;
        gain_next      = gain_reg;
        if (remaining_reg == 20'd0)
        begin
            gain_next = vlfo_pkg::GAIN_ONE;
        end
        else
        begin
            remaining_next = remaining_dec;
            if (remaining_dec != 20'd0)
            begin
                if (gain_sum > {1'b0, vlfo_pkg::GAIN_ONE})
                begin
                    gain_next = vlfo_pkg::GAIN_ONE;
                end
                else
                begin
                    gain_next = gain_sum[16:0];
                end
            end
            else
            begin
                gain_next = vlfo_pkg::GAIN_ONE;
            end
        end
    end

    always_comb
    begin
        if (state_reg == vlfo_pkg::ST_MUL1)
        begin
            mul_a = {15'd0, gain_reg};
            mul_b = {4'd0, rom_data};
        end
        else
        begin
            mul_a = prod_reg[31:0];
            mul_b = depth_q8_reg;
        end
    end

    assign mul_p = {19'd0, mul_a} * {32'd0, mul_b};

    assign rnd_sum = {1'b0, prod_reg} + 52'h40000000;
    assign rnd_mag = rnd_sum[51:31];
    assign mag_sat = (rnd_mag > vlfo_pkg::OUT_MAX) ? vlfo_pkg::OUT_MAX[19:0] : rnd_mag[19:0];

    assign out_load = (state_reg == vlfo_pkg::ST_RND) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vlfo_pkg::ST_IDLE:
            begin
                if (tick_accept)
                begin
                    state_next = vlfo_pkg::ST_MUL1;
                end
            end
            vlfo_pkg::ST_MUL1:
            begin
                state_next = vlfo_pkg::ST_MUL2;
            end
            vlfo_pkg::ST_MUL2:
            begin
                state_next = vlfo_pkg::ST_RND;
            end
            vlfo_pkg::ST_RND:
            begin
                if (out_load)
                begin
                    state_next = vlfo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vlfo_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= vlfo_pkg::ST_IDLE;
            phase_step_reg   <= '0;
            depth_q8_reg     <= '0;
            onset_length_reg <= '0;
            onset_step_reg   <= '0;
            phase_reg        <= '0;
            gain_reg         <= vlfo_pkg::GAIN_ONE;
            remaining_reg    <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    vlfo_pkg::CFG_PHASE_STEP:   phase_step_reg   <= cfg_data[14:0];
                    vlfo_pkg::CFG_DEPTH_Q8:     depth_q8_reg     <= cfg_data[18:0];
                    vlfo_pkg::CFG_ONSET_LENGTH: onset_length_reg <= cfg_data;
                    vlfo_pkg::CFG_ONSET_STEP:   onset_step_reg   <= cfg_data[16:0];
                    default:                    depth_q8_reg     <= depth_q8_reg;
                endcase
            end
            if (note_accept)
            begin
                phase_reg <= s_tdata;
                if (onset_length_reg == 20'd0)
                begin
                    gain_reg      <= vlfo_pkg::GAIN_ONE;
                    remaining_reg <= '0;
                end
                else
                begin
                    gain_reg      <= '0;
                    remaining_reg <= onset_length_reg;
                end
            end
            else if (tick_accept)
            begin
                phase_reg     <= phase_reg + {1'b0, phase_step_reg};
                gain_reg      <= gain_next;
                remaining_reg <= remaining_next;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            neg_reg <= tab_idx[9];
        end
        if ((state_reg == vlfo_pkg::ST_MUL1) || (state_reg == vlfo_pkg::ST_MUL2))
        begin
            prod_reg <= mul_p;
        end
        if (out_load)
        begin
            cents_reg <= neg_reg ? (20'd0 - mag_sat) : mag_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, cents_reg};

    a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= vlfo_pkg::GAIN_ONE)
        else $error("onset gain above unity");

    a_idle_gain_unity: assert property (@(posedge clk) disable iff (!rst_n)
        (remaining_reg == 20'd0) |-> (gain_reg == vlfo_pkg::GAIN_ONE))
        else $error("gain not unity outside the onset ramp");

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> (state_reg == vlfo_pkg::ST_MUL1))
        else $error("accepted tick did not start the sequence");

    a_note_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (note_accept && (onset_length_reg != 20'd0)) |=> (gain_reg == 17'd0))
        else $error("note-on did not restart the onset gain");

endmodule

`default_nettype wire

>>> dv/vlfo_checker.sv
`timescale 1ns / 100ps

module vlfo_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    output int               outstanding,
    output int               mismatches
);

    int          sine_q15 [1024];
    int unsigned phase_inc;
    int unsigned depth;
    int unsigned ramp_len;
    int unsigned ramp_inc;
    int unsigned phase_acc;
    int unsigned gain;
    int unsigned ramp_left;
    logic [19:0] cents_due [$];

    function automatic int quarter_q15(longint u);
        longint u2;
        longint acc;
        longint s;
        u2  = (u * u) / 65536;
        acc = 172272;
        acc = -5026995 + (acc * u2) / 65536;
        acc = 85569306 + (acc * u2) / 65536;
        acc = -693598668 + (acc * u2) / 65536;
        acc = 1686629713 + (acc * u2) / 65536;
        s   = (acc * u) / 65536;
        if (s < 0)
        begin
            s = 0;
        end
        if (s > 64'sd1073741824)
        begin
            s = 64'sd1073741824;
        end
        return int'((s * 32767 + 64'sd536870912) / 64'sd1073741824);
    endfunction

    initial
    begin
        int quad;
        int v;
        for (int k = 0; k < 1024; k++)
        begin
            quad = k / 256;
            if (quad == 0 || quad == 2)
            begin
                v = quarter_q15(longint'(k % 256) * 256);
            end
            else
            begin
                v = quarter_q15(65536 - longint'(k % 256) * 256);
            end
            sine_q15[k] = (quad >= 2) ? -v : v;
        end
    end

    // A sample tick advances the onset gain first, uses the old phase, then steps the phase.
    function automatic logic [19:0] next_cents();
        int                s;
        longint unsigned   mag;
        longint unsigned   prod;
        if (ramp_left == 0)
        begin
            gain = int'(vlfo_pkg::GAIN_ONE);
        end
        else
        begin
            ramp_left = ramp_left - 1;
            if (ramp_left > 0)
            begin
                gain = gain + ramp_inc;
                if (gain > int'(vlfo_pkg::GAIN_ONE))
                begin
                    gain = int'(vlfo_pkg::GAIN_ONE);
                end
            end
            else
            begin
                gain = int'(vlfo_pkg::GAIN_ONE);
            end
        end
        s    = sine_q15[phase_acc >> 6];
        mag  = (s < 0) ? longint'(-s) : longint'(s);
        prod = longint'(depth) * longint'(gain) * mag;
        mag  = (prod + (64'd1 << 30)) >> 31;
        if (mag > 524287)
        begin
            mag = 524287;
        end
        phase_acc = (phase_acc + phase_inc) & 32'hFFFF;
        return (s < 0) ? 20'(-longint'(mag)) : 20'(mag);
    endfunction

    task automatic note_mismatch(input string what, input logic [23:0] exp_word,
                                 input logic [23:0] act_word);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%t: %s: expected %h, got %h", $realtime, what, exp_word, act_word);
        end
    endtask

    always @(posedge clk)
    begin
        logic [19:0] exp_cents;
        if (!rst_n)
        begin
            phase_inc = 0;
            depth     = 0;
            ramp_len  = 0;
            ramp_inc  = 0;
            phase_acc = 0;
            gain      = int'(vlfo_pkg::GAIN_ONE);
            ramp_left = 0;
            cents_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    vlfo_pkg::CFG_PHASE_STEP:   phase_inc = cfg_data[14:0];
                    vlfo_pkg::CFG_DEPTH_Q8:     depth     = cfg_data[18:0];
                    vlfo_pkg::CFG_ONSET_LENGTH: ramp_len  = cfg_data[19:0];
                    vlfo_pkg::CFG_ONSET_STEP:   ramp_inc  = cfg_data[16:0];
                    default:                    ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == vlfo_pkg::OP_NOTE_ON)
                begin
                    phase_acc = s_tdata;
                    gain      = (ramp_len == 0) ? int'(vlfo_pkg::GAIN_ONE) : 0;
                    ramp_left = ramp_len;
                end
                else
                begin
                    cents_due.push_back(next_cents());
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (cents_due.size() == 0)
                begin
                    note_mismatch("unexpected word", 24'h0, m_tdata);
                end
                else
                begin
                    exp_cents = cents_due.pop_front();
                    if (m_tdata != {4'h0, exp_cents})
                    begin
                        note_mismatch("cents_q8", {4'h0, exp_cents}, m_tdata);
                    end
                end
            end
        end
        outstanding = cents_due.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'h0;
    logic        s_tuser   = vlfo_pkg::OP_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = vlfo_pkg::CFG_PHASE_STEP;
    logic [19:0] cfg_data  = 20'h0;
    int          outstanding;
    int          mismatches;
    bit          calm      = 1'b0;

    vibrato_lfo_with_onset_ramp_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vlfo_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 24);
    end

    task automatic send_word(input logic op, input logic [15:0] start_phase);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 24)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= start_phase;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    task automatic play_note(input logic [15:0] start_phase, input int ticks);
        send_word(vlfo_pkg::OP_NOTE_ON, start_phase);
        repeat (ticks)
        begin
            send_word(vlfo_pkg::OP_TICK, 16'($urandom));
        end
    endtask

    // A note-on gives no word, so the task keeps clocking once the last word is in.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [19:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
    endtask

    task automatic configure(input logic [19:0] inc, input logic [19:0] dep,
                             input logic [19:0] len, input logic [19:0] ginc);
        write_reg(vlfo_pkg::CFG_PHASE_STEP, inc);
        write_reg(vlfo_pkg::CFG_DEPTH_Q8, dep);
        write_reg(vlfo_pkg::CFG_ONSET_LENGTH, len);
        write_reg(vlfo_pkg::CFG_ONSET_STEP, ginc);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [19:0] pick(input logic [19:0] max_val);
        case ($urandom_range(0, 3))
            0:       return 20'h0;
            1:       return max_val;
            default: return 20'($urandom) & max_val;
        endcase
    endfunction

    initial
    begin
        int          sent;
        int          ticks;
        logic [19:0] len;
        logic [19:0] ginc;
        logic [19:0] dep;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(vlfo_pkg::OP_TICK, 16'h0000);
        send_word(vlfo_pkg::OP_TICK, 16'hFFFF);
        drain();
        configure(20'h7FFF, 20'h7FFFF, 20'h0, 20'h0);
        send_word(vlfo_pkg::OP_TICK, 16'h0000);
        play_note(16'h4000, 1);
        play_note(16'hFFFF, 2);
        play_note(16'h8000, 1);
        play_note(16'hC000, 2);
        drain();
        configure(20'h1, 20'd307200, 20'd3, 20'h1FFFF);
        play_note(16'h4000, 4);
        drain();
        configure(20'h1, 20'd307200, 20'd1, 20'h0);
        play_note(16'h1234, 2);

        for (int phase = 0; phase < 12; phase++)
        begin
            drain();
            calm = (phase == 5 || phase == 6);
            case ($urandom_range(0, 9))
                0, 1:    len = 20'h0;
                2:       len = 20'hFFFFF;
                3:       len = 20'h1;
                default: len = $urandom_range(2, 48);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ginc = (len != 0) ? 20'(65536 / len) : 20'd65536;
                4:          ginc = 20'h1FFFF;
                5:          ginc = 20'h0;
                default:    ginc = 20'($urandom) & 20'h1FFFF;
            endcase
            dep = ($urandom_range(0, 5) == 0) ? 20'd307200 : pick(20'h7FFFF);
            configure(pick(20'h7FFF), dep, len, ginc);
            sent = 0;
            while (sent < 140)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_word($urandom_range(0, 1) ? vlfo_pkg::OP_NOTE_ON : vlfo_pkg::OP_TICK,
                              16'($urandom));
                    sent++;
                end
                else
                begin
                    ticks = $urandom_range(0, 40);
                    play_note(16'($urandom), ticks);
                    sent += ticks + 1;
                end
            end
        end

        drain();
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/vlfo_pkg.sv
hw/rtl/vlfo_sine_rom.sv
hw/rtl/vibrato_lfo_with_onset_ramp_unit.sv
dv/vlfo_checker.sv
dv/testbench.sv
